// ===== rtl/ipc_pkg.sv =====
// ipc_pkg: shared types, codes and reset constants for the pump controller
// no dependencies; used by every module in rtl/

package ipc_pkg;

    localparam int COUNT_WIDTH_DEF = 16;

    localparam int MOIST_W = 10;
    localparam int LIMIT_W = 16;
    localparam int CFG_W   = 16;
    localparam int IDX_W   = 3;
    localparam int ELAP_W  = 16;

    typedef enum logic [IDX_W-1:0] {
        REG_LOW_THRESHOLD     = 3'd0,
        REG_HIGH_THRESHOLD    = 3'd1,
        REG_AUTO_TIME_LIMIT   = 3'd2,
        REG_MANUAL_TIME_LIMIT = 3'd3,
        REG_ALERT_MARGIN      = 3'd4
    } reg_idx_t;

    typedef enum logic [1:0] {
        CMD_TICK   = 2'd0,
        CMD_TOGGLE = 2'd1,
        CMD_START  = 2'd2
    } cmd_t;

    typedef enum logic [1:0] {
        IND_NORMAL   = 2'd0,
        IND_WATERING = 2'd1,
        IND_ERROR    = 2'd2,
        IND_ALERT    = 2'd3
    } ind_t;

    typedef enum logic [1:0] {
        ST_OK          = 2'd0,
        ST_NOT_MANUAL  = 2'd1,
        ST_ALREADY_ON  = 2'd2
    } status_t;

    localparam logic [MOIST_W-1:0] LOW_THRESHOLD_RST     = 10'd300;
    localparam logic [MOIST_W-1:0] HIGH_THRESHOLD_RST    = 10'd700;
    localparam logic [LIMIT_W-1:0] AUTO_TIME_LIMIT_RST   = 16'd300;
    localparam logic [LIMIT_W-1:0] MANUAL_TIME_LIMIT_RST = 16'd60;
    localparam logic [MOIST_W-1:0] ALERT_MARGIN_RST      = 10'd50;

    typedef struct packed {
        logic [MOIST_W-1:0] low_threshold;
        logic [MOIST_W-1:0] high_threshold;
        logic [LIMIT_W-1:0] auto_time_limit;
        logic [LIMIT_W-1:0] manual_time_limit;
        logic [MOIST_W-1:0] alert_margin;
    } cfg_t;

    typedef struct packed {
        logic manual;
        logic pump;
        ind_t ind;
    } flags_t;

endpackage

// ===== rtl/ipc_cfg.sv =====
// ipc_cfg: configuration register file, written through a plain write port
// depends on ipc_pkg

module ipc_cfg (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [ipc_pkg::IDX_W-1:0]   cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]   cfg_wdata,
    output ipc_pkg::cfg_t               cfg
);
    import ipc_pkg::*;

    cfg_t cfg_reg;
    cfg_t cfg_next;

    always_comb
    begin
        cfg_next = cfg_reg;
        if (cfg_we)
        begin
            case (reg_idx_t'(cfg_index))
                REG_LOW_THRESHOLD:     cfg_next.low_threshold     = cfg_wdata[MOIST_W-1:0];
                REG_HIGH_THRESHOLD:    cfg_next.high_threshold    = cfg_wdata[MOIST_W-1:0];
                REG_AUTO_TIME_LIMIT:   cfg_next.auto_time_limit   = cfg_wdata[LIMIT_W-1:0];
                REG_MANUAL_TIME_LIMIT: cfg_next.manual_time_limit = cfg_wdata[LIMIT_W-1:0];
                REG_ALERT_MARGIN:      cfg_next.alert_margin      = cfg_wdata[MOIST_W-1:0];
                default:               cfg_next = cfg_reg;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.low_threshold     <= LOW_THRESHOLD_RST;
            cfg_reg.high_threshold    <= HIGH_THRESHOLD_RST;
            cfg_reg.auto_time_limit   <= AUTO_TIME_LIMIT_RST;
            cfg_reg.manual_time_limit <= MANUAL_TIME_LIMIT_RST;
            cfg_reg.alert_margin      <= ALERT_MARGIN_RST;
        end
        else
        begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== rtl/ipc_logic.sv =====
// ipc_logic: next-state and status logic for one beat (pump, mode, indicator, run count)
// depends on ipc_pkg

module ipc_logic #(
    parameter int COUNT_WIDTH = ipc_pkg::COUNT_WIDTH_DEF
) (
    input  ipc_pkg::cfg_t                 cfg,
    input  logic [1:0]                    cmd,
    input  logic [ipc_pkg::MOIST_W-1:0]   moisture,
    input  ipc_pkg::flags_t               flags,
    input  logic [COUNT_WIDTH-1:0]        cnt,
    output ipc_pkg::flags_t               flags_next,
    output logic [COUNT_WIDTH-1:0]        cnt_next,
    output ipc_pkg::status_t              status
);
    import ipc_pkg::*;

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [COUNT_WIDTH-1:0] cnt_inc;
    logic [CMP_W-1:0]       inc_ext;
    logic                   auto_limit_hit;
    logic                   manual_limit_hit;
    logic [MOIST_W:0]       alert_sum;
    logic                   alert;

    // saturating run counter
    assign cnt_inc = (&cnt) ? cnt : cnt + COUNT_WIDTH'(1);
    assign inc_ext = CMP_W'(cnt_inc);
    assign auto_limit_hit   = inc_ext >= CMP_W'(cfg.auto_time_limit);
    assign manual_limit_hit = inc_ext >= CMP_W'(cfg.manual_time_limit);

    assign alert_sum = {1'b0, moisture} + {1'b0, cfg.alert_margin};
    assign alert     = alert_sum < {1'b0, cfg.low_threshold};

    always_comb
    begin
        flags_next = flags;
        cnt_next   = cnt;
        status     = ST_OK;
        case (cmd_t'(cmd))
            CMD_TICK:
            begin
                if (flags.manual)
                begin
                    if (flags.pump)
                    begin
                        cnt_next = cnt_inc;
                        if (manual_limit_hit)
                        begin
                            flags_next.pump = 1'b0;
                            flags_next.ind  = IND_NORMAL;
                            cnt_next        = '0;
                        end
                    end
                end
                else
                begin
                    if (!flags.pump)
                    begin
                        if (moisture < cfg.low_threshold)
                        begin
                            flags_next.pump = 1'b1;
                            flags_next.ind  = IND_WATERING;
                            cnt_next        = '0;
                        end
                    end
                    else
                    begin
                        cnt_next = cnt_inc;
                        if (moisture > cfg.high_threshold || auto_limit_hit)
                        begin
                            flags_next.pump = 1'b0;
                            cnt_next        = '0;
                        end
                    end
                    // led step follows the pump step; a stopped pump shows alert or normal, never the error code
                    if (!flags_next.pump)
                    begin
                        flags_next.ind = alert ? IND_ALERT : IND_NORMAL;
                    end
                end
            end
            CMD_TOGGLE:
            begin
                flags_next.manual = ~flags.manual;
                flags_next.pump   = 1'b0;
                flags_next.ind    = IND_NORMAL;
                if (flags.pump)
                begin
                    cnt_next = '0;
                end
            end
            CMD_START:
            begin
                if (!flags.manual)
                begin
                    status = ST_NOT_MANUAL;
                end
                else if (flags.pump)
                begin
                    status = ST_ALREADY_ON;
                end
                else
                begin
                    flags_next.pump = 1'b1;
                    flags_next.ind  = IND_WATERING;
                    cnt_next        = '0;
                end
            end
            default:
            begin
                flags_next = flags;
            end
        endcase
    end

endmodule

// ===== rtl/irrigation_pump_controller_unit.sv =====
// irrigation pump controller: input register, one-beat state update, result register
// an accepted beat passes the input register, then the result register, which raises out_valid
// throughput: one beat per cycle while out_stall is low, set by the single pass through ipc_logic
// the result register holds a stalled beat while the input register takes the next one
// reset: auto mode, pump off, indicator normal, count zero, registers at defaults
// depends on ipc_pkg, ipc_cfg, ipc_logic

module irrigation_pump_controller_unit #(
    parameter int COUNT_WIDTH = ipc_pkg::COUNT_WIDTH_DEF
) (
    input  logic                          clk,
    input  logic                          rst_n,
    input  logic                          cfg_we,
    input  logic [ipc_pkg::IDX_W-1:0]     cfg_index,
    input  logic [ipc_pkg::CFG_W-1:0]     cfg_wdata,
    input  logic                          in_valid,
    output logic                          in_stall,
    input  logic [1:0]                    cmd,
    input  logic [ipc_pkg::MOIST_W-1:0]   moisture,
    output logic                          out_valid,
    input  logic                          out_stall,
    output logic                          pump_running,
    output logic [1:0]                    indicator,
    output logic                          manual_mode,
    output logic [ipc_pkg::ELAP_W-1:0]    elapsed_seconds,
    output logic [1:0]                    status
);
    import ipc_pkg::*;

    localparam int EXT_W = (COUNT_WIDTH > ELAP_W) ? COUNT_WIDTH : ELAP_W;

    cfg_t                   cfg;

    logic                   in_valid_reg;
    logic                   in_valid_next;
    logic [1:0]             cmd_reg;
    logic [MOIST_W-1:0]     moisture_reg;
    logic                   in_take;
    logic                   advance;

    flags_t                 flags_reg;
    flags_t                 flags_next;
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [COUNT_WIDTH-1:0] cnt_next;
    status_t                status_next;

    logic                   out_valid_reg;
    logic                   out_valid_next;
    logic                   pump_reg;
    logic [1:0]             ind_reg;
    logic                   manual_reg;
    logic [ELAP_W-1:0]      elapsed_reg;
    logic [1:0]             status_reg;
    logic [EXT_W-1:0]       cnt_ext;

    ipc_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata),
        .cfg       (cfg)
    );

    ipc_logic #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_logic (
        .cfg        (cfg),
        .cmd        (cmd_reg),
        .moisture   (moisture_reg),
        .flags      (flags_reg),
        .cnt        (cnt_reg),
        .flags_next (flags_next),
        .cnt_next   (cnt_next),
        .status     (status_next)
    );

    // a held beat moves on when the result register is empty or being drained
    assign advance        = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall       = in_valid_reg && !advance;
    assign in_take        = in_valid && !in_stall;
    assign in_valid_next  = in_take || (in_valid_reg && !advance);
    assign out_valid_next = advance || (out_valid_reg && out_stall);
    assign cnt_ext        = EXT_W'(cnt_next);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            flags_reg     <= '{manual: 1'b0, pump: 1'b0, ind: IND_NORMAL};
            cnt_reg       <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (advance)
            begin
                flags_reg <= flags_next;
                cnt_reg   <= cnt_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_take)
        begin
            cmd_reg      <= cmd;
            moisture_reg <= moisture;
        end
        if (advance)
        begin
            pump_reg    <= flags_next.pump;
            ind_reg     <= flags_next.ind;
            manual_reg  <= flags_next.manual;
            elapsed_reg <= cnt_ext[ELAP_W-1:0];
            status_reg  <= status_next;
        end
    end

    assign out_valid       = out_valid_reg;
    assign pump_running    = pump_reg;
    assign indicator       = ind_reg;
    assign manual_mode     = manual_reg;
    assign elapsed_seconds = elapsed_reg;
    assign status          = status_reg;

endmodule

// ===== bench/irrigation_pump_controller_unit_tb.sv =====
`timescale 1ns / 1ps
// testbench for irrigation_pump_controller_unit: directed and random command beats,
// every result beat checked field by field against a local model of the pump state
// depends on ipc_pkg and the controller rtl

module irrigation_pump_controller_unit_tb;
    import ipc_pkg::*;

    localparam logic [1:0] CMD_UNUSED = 2'd3;
    localparam int COUNT_MAX = 65535;
    localparam int CYCLE_LIMIT = 200_000;
    localparam int PHASE_BEATS = 235;
    localparam int PHASES = 8;

    typedef enum int {
        STALL_NONE,
        STALL_PERIODIC,
        STALL_RANDOM,
        STALL_LONG
    } stall_mode_t;

    typedef struct {
        logic              pump;
        ind_t              ind;
        logic              manual;
        logic [ELAP_W-1:0] elapsed;
        status_t           st;
    } pump_report_t;

    logic                clk = 1'b0;
    logic                rst_n = 1'b0;
    logic                cfg_we = 1'b0;
    logic [IDX_W-1:0]    cfg_index = '0;
    logic [CFG_W-1:0]    cfg_wdata = '0;
    logic                in_valid = 1'b0;
    logic                in_stall;
    logic [1:0]          cmd = CMD_TICK;
    logic [MOIST_W-1:0]  moisture = '0;
    logic                out_valid;
    logic                out_stall = 1'b0;
    logic                pump_running;
    logic [1:0]          indicator;
    logic                manual_mode;
    logic [ELAP_W-1:0]   elapsed_seconds;
    logic [1:0]          status;

    // local copy of the controller state and its registers
    cfg_t                model_cfg;
    logic                model_manual;
    logic                model_pump;
    ind_t                model_ind;
    int unsigned         model_count;
    pump_report_t        pending_reports[$];

    int                  errors = 0;
    int                  cyc = 0;
    int                  stall_tick = 0;
    stall_mode_t         stall_mode = STALL_NONE;
    int                  gap_max = 0;
    int                  burst_left = 0;
    bit                  valid_hi = 0;

    irrigation_pump_controller_unit i_dut (
        .clk             (clk),
        .rst_n           (rst_n),
        .cfg_we          (cfg_we),
        .cfg_index       (cfg_index),
        .cfg_wdata       (cfg_wdata),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .cmd             (cmd),
        .moisture        (moisture),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .pump_running    (pump_running),
        .indicator       (indicator),
        .manual_mode     (manual_mode),
        .elapsed_seconds (elapsed_seconds),
        .status          (status)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    function automatic void stop_run(input ind_t ind);
        model_pump  = 1'b0;
        model_ind   = ind;
        model_count = 0;
    endfunction

    function automatic void count_tick();
        if (model_count < COUNT_MAX)
            model_count++;
    endfunction

    function automatic void update_pump_state(input logic [1:0] c, input logic [MOIST_W-1:0] m);
        pump_report_t r;
        status_t      st;
        st = ST_OK;
        case (c)
            CMD_TICK:
            begin
                if (model_manual)
                begin
                    if (model_pump)
                    begin
                        count_tick();
                        if (model_count >= model_cfg.manual_time_limit)
                            stop_run(IND_NORMAL);
                    end
                end
                else
                begin
                    if (!model_pump)
                    begin
                        if (m < model_cfg.low_threshold)
                        begin
                            model_pump  = 1'b1;
                            model_count = 0;
                            model_ind   = IND_WATERING;
                        end
                    end
                    else
                    begin
                        count_tick();
                        if (m > model_cfg.high_threshold)
                            stop_run(IND_NORMAL);
                        else if (model_count >= model_cfg.auto_time_limit)
                            stop_run(IND_ERROR);
                    end
                    // led step runs last, so a timeout shows as alert or normal
                    if (!model_pump)
                        model_ind = (int'(m) + int'(model_cfg.alert_margin)
                                     < int'(model_cfg.low_threshold)) ? IND_ALERT : IND_NORMAL;
                end
            end
            CMD_TOGGLE:
            begin
                model_manual = !model_manual;
                if (model_pump)
                begin
                    model_pump  = 1'b0;
                    model_count = 0;
                end
                model_ind = IND_NORMAL;
            end
            CMD_START:
            begin
                if (!model_manual)
                    st = ST_NOT_MANUAL;
                else if (model_pump)
                    st = ST_ALREADY_ON;
                else
                begin
                    model_pump  = 1'b1;
                    model_count = 0;
                    model_ind   = IND_WATERING;
                end
            end
            default:
            begin
            end
        endcase
        r.pump    = model_pump;
        r.ind     = model_ind;
        r.manual  = model_manual;
        r.elapsed = model_count[ELAP_W-1:0];
        r.st      = st;
        pending_reports.push_back(r);
    endfunction

    // follow register writes and accepted command beats
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (cfg_we)
            begin
                case (cfg_index)
                    REG_LOW_THRESHOLD:     model_cfg.low_threshold     = cfg_wdata[MOIST_W-1:0];
                    REG_HIGH_THRESHOLD:    model_cfg.high_threshold    = cfg_wdata[MOIST_W-1:0];
                    REG_AUTO_TIME_LIMIT:   model_cfg.auto_time_limit   = cfg_wdata[LIMIT_W-1:0];
                    REG_MANUAL_TIME_LIMIT: model_cfg.manual_time_limit = cfg_wdata[LIMIT_W-1:0];
                    REG_ALERT_MARGIN:      model_cfg.alert_margin      = cfg_wdata[MOIST_W-1:0];
                    default:
                    begin
                    end
                endcase
            end
            if (in_valid && !in_stall)
                update_pump_state(cmd, moisture);
        end
    end

    always @(posedge clk)
    begin
        pump_report_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (pending_reports.size() == 0)
            begin
                $error("result beat arrived with nothing expected");
                errors++;
            end
            else
            begin
                want = pending_reports.pop_front();
                if (pump_running !== want.pump)
                begin
                    $error("pump_running: expected %0d, got %0d", want.pump, pump_running);
                    errors++;
                end
                if (indicator !== want.ind)
                begin
                    $error("indicator: expected %0d, got %0d", want.ind, indicator);
                    errors++;
                end
                if (manual_mode !== want.manual)
                begin
                    $error("manual_mode: expected %0d, got %0d", want.manual, manual_mode);
                    errors++;
                end
                if (elapsed_seconds !== want.elapsed)
                begin
                    $error("elapsed_seconds: expected %0d, got %0d", want.elapsed,
                           elapsed_seconds);
                    errors++;
                end
                if (status !== want.st)
                begin
                    $error("status: expected %0d, got %0d", want.st, status);
                    errors++;
                end
            end
        end
    end

    // receiver back-pressure
    always @(posedge clk)
    begin
        stall_tick++;
        case (stall_mode)
            STALL_NONE:     out_stall <= 1'b0;
            STALL_PERIODIC: out_stall <= (stall_tick % 11) < 4;
            STALL_RANDOM:   out_stall <= $urandom_range(0, 99) < 45;
            default:        out_stall <= (stall_tick % 37) < 20;
        endcase
    end

    always @(posedge clk)
    begin
        cyc++;
        if (cyc > CYCLE_LIMIT)
        begin
            $display("== FAIL ==");
            $finish;
        end
    end

    task automatic send_beat(input logic [1:0] c, input int m);
        in_valid <= 1'b1;
        cmd      <= c;
        moisture <= m[MOIST_W-1:0];
        valid_hi = 1;
        do
            @(posedge clk);
        while (in_stall);
        if (gap_max > 0)
        begin
            if (burst_left == 0)
            begin
                in_valid <= 1'b0;
                valid_hi = 0;
                repeat ($urandom_range(1, gap_max)) @(posedge clk);
                burst_left = $urandom_range(1, 12);
            end
            else
                burst_left--;
        end
    endtask

    task automatic pause_until_drained();
        if (valid_hi)
        begin
            in_valid <= 1'b0;
            valid_hi = 0;
        end
        // wait for a clock edge so the last accepted beat is already in the queue
        @(posedge clk);
        while (pending_reports.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_reg(input reg_idx_t idx, input int unsigned val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val[CFG_W-1:0];
        @(posedge clk);
    endtask

    task automatic write_config(input int unsigned lo, input int unsigned hi,
                                input int unsigned at, input int unsigned mt,
                                input int unsigned mg);
        put_reg(REG_LOW_THRESHOLD, lo);
        put_reg(REG_HIGH_THRESHOLD, hi);
        put_reg(REG_AUTO_TIME_LIMIT, at);
        put_reg(REG_MANUAL_TIME_LIMIT, mt);
        put_reg(REG_ALERT_MARGIN, mg);
        cfg_we <= 1'b0;
    endtask

    function automatic logic [1:0] pick_cmd();
        int r;
        r = $urandom_range(0, 99);
        if (r < 72)
            return CMD_TICK;
        else if (r < 80)
            return CMD_TOGGLE;
        else if (r < 93)
            return CMD_START;
        else
            return CMD_UNUSED;
    endfunction

    // samples cluster around the thresholds so starts, stops and alerts flip often
    function automatic int pick_moisture();
        int m;
        case ($urandom_range(0, 4))
            0: m = int'(model_cfg.low_threshold) + int'($urandom_range(0, 6)) - 3;
            1: m = int'(model_cfg.high_threshold) + int'($urandom_range(0, 6)) - 3;
            2: m = int'(model_cfg.low_threshold) - int'(model_cfg.alert_margin)
                   + int'($urandom_range(0, 4)) - 2;
            3: m = $urandom_range(0, 1) ? 0 : 1023;
            default: m = $urandom_range(0, 1023);
        endcase
        if (m < 0)
            m = 0;
        if (m > 1023)
            m = 1023;
        return m;
    endfunction

    task automatic test_reset_defaults();
        gap_max    = 2;
        stall_mode = STALL_PERIODIC;
        send_beat(CMD_TICK, 1000);
        send_beat(CMD_TICK, 1023);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TICK, 700);
        send_beat(CMD_TICK, 701);
        send_beat(CMD_UNUSED, 555);
        send_beat(CMD_START, 0);
        send_beat(CMD_TICK, 299);
        send_beat(CMD_TOGGLE, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_START, 0);
        send_beat(CMD_START, 1023);
        send_beat(CMD_TICK, 512);
        send_beat(CMD_TICK, 341);
        send_beat(CMD_UNUSED, 0);
        send_beat(CMD_TOGGLE, 1023);
        send_beat(CMD_TICK, 249);
        pause_until_drained();
    endtask

    task automatic test_limits_and_alerts();
        // timeout turns into alert; a zero manual limit stops on the first tick
        write_config(1000, 1000, 1, 0, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TICK, 1000);
        send_beat(CMD_TICK, 999);
        send_beat(CMD_TICK, 1001);
        send_beat(CMD_TOGGLE, 0);
        send_beat(CMD_START, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TOGGLE, 0);
        pause_until_drained();
        // margin above the low threshold never raises the alert
        write_config(10, 1000, 3, 1, 1000);
        repeat (5) send_beat(CMD_TICK, 0);
        pause_until_drained();
    endtask

    task automatic test_manual_run();
        gap_max    = 0;
        stall_mode = STALL_NONE;
        write_config(LOW_THRESHOLD_RST, HIGH_THRESHOLD_RST, AUTO_TIME_LIMIT_RST,
                     40, ALERT_MARGIN_RST);
        send_beat(CMD_TOGGLE, 0);
        send_beat(CMD_START, 0);
        repeat (41) send_beat(CMD_TICK, $urandom_range(0, 1023));
        send_beat(CMD_START, 0);
        send_beat(CMD_TICK, 0);
        send_beat(CMD_TOGGLE, 0);
        pause_until_drained();
    endtask

    task automatic test_random_traffic();
        int unsigned lo;
        int unsigned hi;
        int unsigned at;
        int unsigned mt;
        int unsigned mg;
        int          pressure_at;
        for (int phase = 0; phase < PHASES; phase++)
        begin
            if (phase == 0)
            begin
                write_config(1000, 1000, 65535, 65535, 1000);
                gap_max    = 0;
                stall_mode = STALL_NONE;
            end
            else if (phase == 1)
            begin
                write_config(0, 0, 1, 1, 0);
                gap_max    = 4;
                stall_mode = STALL_RANDOM;
            end
            else
            begin
                lo = $urandom_range(0, 1000);
                hi = $urandom_range(0, 1000);
                at = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
                mt = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 65535) : $urandom_range(1, 40);
                mg = ($urandom_range(0, 3) == 0) ? $urandom_range(0, 1000) : $urandom_range(0, 120);
                write_config(lo, hi, at, mt, mg);
                gap_max    = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
                stall_mode = stall_mode_t'($urandom_range(0, 3));
            end
            pressure_at = $urandom_range(20, PHASE_BEATS - 20);
            for (int k = 0; k < PHASE_BEATS; k++)
            begin
                if (k == pressure_at)
                    pause_until_drained();
                send_beat(pick_cmd(), pick_moisture());
            end
            pause_until_drained();
        end
    endtask

    initial
    begin
        model_cfg.low_threshold     = LOW_THRESHOLD_RST;
        model_cfg.high_threshold    = HIGH_THRESHOLD_RST;
        model_cfg.auto_time_limit   = AUTO_TIME_LIMIT_RST;
        model_cfg.manual_time_limit = MANUAL_TIME_LIMIT_RST;
        model_cfg.alert_margin      = ALERT_MARGIN_RST;
        model_manual = 1'b0;
        model_pump   = 1'b0;
        model_ind    = IND_NORMAL;
        model_count  = 0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        test_reset_defaults();
        test_limits_and_alerts();
        test_manual_run();
        test_random_traffic();
        pause_until_drained();
        repeat (10) @(posedge clk);
        if (errors == 0)
            $display("== PASS ==");
        else
            $display("== FAIL ==");
        $finish;
    end

endmodule

// ===== irrigation_pump_controller_unit.f =====
rtl/ipc_pkg.sv
rtl/ipc_cfg.sv
rtl/ipc_logic.sv
rtl/irrigation_pump_controller_unit.sv
bench/irrigation_pump_controller_unit_tb.sv
